// File: rtl/mbe_pkg.sv
// Shared types, constants and arithmetic helpers of the escape-time evaluator.
// Used by the multiplier cells, the multiplier chain and the top level.
package mbe_pkg;

  localparam int unsigned WIDTH     = 800;
  localparam int unsigned HEIGHT    = 600;
  localparam int unsigned FRAC_BITS = 40;

  localparam int unsigned WORD_W    = 48;
  localparam int unsigned STEP_W    = 41;
  localparam int unsigned ITER_W    = 16;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned DX_W      = 13;
  localparam int unsigned PRE_W     = DX_W + STEP_W + 1;
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned NUM_CELLS = WORD_W / DIGIT_W;
  localparam int unsigned PROD_W    = 2 * WORD_W;
  localparam int unsigned Q_W       = 63;
  localparam int unsigned EXT_W     = 66;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [Q_W-1:0] CAP62 = Q_W'(64'h4000_0000_0000_0000);
  localparam logic [63:0]    FOUR  = 64'(64'd4 << FRAC_BITS);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [EXT_W-1:0]  ext_t;

  typedef enum logic [1:0] {
    TAG_SQ_RE,
    TAG_SQ_IM,
    TAG_CROSS
  } mul_tag_e;

  typedef struct packed {
    logic     valid;
    mul_tag_e tag;
  } mul_ctl_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER_RE = 3'd0,
    REG_CENTER_IM = 3'd1,
    REG_STEP_RE   = 3'd2,
    REG_STEP_IM   = 3'd3,
    REG_MAX_ITER  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT,
    ST_UPDATE,
    ST_DONE
  } state_e;

  function automatic word_t sat48(input ext_t v);
    ext_t vmax;
    ext_t vmin;
    vmax = $signed({{(EXT_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}});
    vmin = $signed({{(EXT_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}});
    if (v > vmax) begin
      return vmax[WORD_W-1:0];
    end else if (v < vmin) begin
      return vmin[WORD_W-1:0];
    end
    return v[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] mag48(input word_t v);
    return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
  endfunction

  function automatic logic [Q_W-1:0] cap_q(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p >> FRAC_BITS;
    if (s > PROD_W'(CAP62)) begin
      return CAP62;
    end
    return s[Q_W-1:0];
  endfunction

  function automatic logic prod_rem(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] m;
    m = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
    return |(p & m);
  endfunction

endpackage

// File: rtl/mbe_mul_cell.sv
// One cell of the multiplier chain: adds one 8-bit digit's partial product.
// Depends on mbe_pkg.
module mbe_mul_cell import mbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mul_ctl_t          ctl_i,
  input  logic [PROD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  input  logic [PROD_W-1:0] acc_i,
  output mul_ctl_t          ctl_o,
  output logic [PROD_W-1:0] a_o,
  output logic [WORD_W-1:0] b_o,
  output logic [PROD_W-1:0] acc_o
);

  mul_ctl_t          ctl_q;
  logic [PROD_W-1:0] a_q, acc_q, acc_d;
  logic [WORD_W-1:0] b_q;

  assign acc_d = acc_i + PROD_W'(a_i * PROD_W'(b_i[DIGIT_W-1:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_i << DIGIT_W;
    b_q   <= b_i >> DIGIT_W;
    acc_q <= acc_d;
  end

  assign ctl_o = ctl_q;
  assign a_o   = a_q;
  assign b_o   = b_q;
  assign acc_o = acc_q;

endmodule

// File: rtl/mbe_mul_chain.sv
// Row of multiplier cells forming a pipelined 48 x 48 bit unsigned multiplier.
// Depends on mbe_pkg and mbe_mul_cell.
module mbe_mul_chain import mbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mul_ctl_t          ctl_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output mul_ctl_t          ctl_o,
  output logic [PROD_W-1:0] p_o
);

  mul_ctl_t          ctl_s [NUM_CELLS+1];
  logic [PROD_W-1:0] a_s   [NUM_CELLS+1];
  logic [WORD_W-1:0] b_s   [NUM_CELLS+1];
  logic [PROD_W-1:0] acc_s [NUM_CELLS+1];

  assign ctl_s[0] = ctl_i;
  assign a_s[0]   = PROD_W'(a_i);
  assign b_s[0]   = b_i;
  assign acc_s[0] = '0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mbe_mul_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[k]),
      .a_i    (a_s[k]),
      .b_i    (b_s[k]),
      .acc_i  (acc_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .a_o    (a_s[k+1]),
      .b_o    (b_s[k+1]),
      .acc_o  (acc_s[k+1])
    );
  end

  assign ctl_o = ctl_s[NUM_CELLS];
  assign p_o   = acc_s[NUM_CELLS];

endmodule

// File: rtl/mandelbrot_escape_time.sv
// Escape-time evaluator: maps a pixel to a complex point and iterates z = z*z + c.
// Depends on mbe_pkg and mbe_mul_chain.
//
// The slave stream carries one pixel per transaction; the master stream returns the
// pixel, its escape count and an inside flag. Configuration is written through a plain
// write port (index 0 to 4: center_re, center_im, step_re, step_im, max_iter); the user
// must write it only while the block is idle, which the block itself does not enforce.
// One pixel is processed at a time. After acceptance, ST_MAP and ST_LOAD map it to c.
// Each iteration then issues three products into a six-cell multiplier chain, waits
// for the last one and updates z. Each iteration depends on the previous z through
// the multiplier chain, so the iterations of a pixel are not overlapped.
// Reset loads the default view and clears all valid state. A finished result waits in
// the output register; while it is not taken, the next pixel is still accepted and
// computed, and the block holds its own result until the output register is free.
module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pixel_x [9:0], pixel_y [19:10], zero padding [23:20]
  input  logic [23:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_x [9:0], out_y [19:10], escape_count [35:20], zero padding [39:36]
  output logic [39:0]          m_axis_tdata,
  // inside_res [0]
  output logic                 m_axis_tuser,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i
);

  state_e            state_q, state_d;
  mul_tag_e          tag_q, tag_d, tag_next;
  logic [ITER_W:0]   iter_q, iter_d;

  word_t             center_re_q, center_im_q;
  logic [STEP_W-1:0] step_re_q, step_im_q;
  logic [ITER_W-1:0] max_iter_q;

  logic [COORD_W-1:0] px_q, py_q;
  logic signed [PRE_W-1:0] pre_re_q, pre_im_q;
  logic signed [DX_W-1:0]  dx, dy;
  word_t             cre_q, cim_q, zre_q, zim_q, ri_q, nre, nim, rr, ii;
  logic [Q_W-1:0]    q_re_q, q_im_q, q_out;
  logic              inside_q, escaped, q_rem;
  ext_t              ri_full;

  logic [COORD_W-1:0] out_x_q, out_y_q;
  logic [ITER_W-1:0]  out_count_q;
  logic               out_inside_q, out_valid_q;

  mul_ctl_t          mul_in_ctl, mul_out_ctl;
  logic [WORD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  logic s_accept, out_load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q <= WORD_W'(64'd10995116278);
      center_im_q <= WORD_W'(64'd10995116278);
      step_re_q   <= STEP_W'(64'd5497558139);
      step_im_q   <= STEP_W'(64'd7330077518);
      max_iter_q  <= ITER_W'(7000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CENTER_RE: center_re_q <= cfg_wdata_i;
        REG_CENTER_IM: center_im_q <= cfg_wdata_i;
        REG_STEP_RE:   step_re_q   <= cfg_wdata_i[STEP_W-1:0];
        REG_STEP_IM:   step_im_q   <= cfg_wdata_i[STEP_W-1:0];
        REG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (tag_q)
      TAG_SQ_RE: tag_next = TAG_SQ_IM;
      TAG_SQ_IM: tag_next = TAG_CROSS;
      default:   tag_next = TAG_SQ_RE;
    endcase
  end

  // Datapath of one iteration.
  assign rr      = sat48(ext_t'($signed({3'b000, q_re_q})));
  assign ii      = sat48(ext_t'($signed({3'b000, q_im_q})));
  assign nre     = sat48(ext_t'(rr) - ext_t'(ii) + ext_t'(cre_q));
  assign nim     = sat48((ext_t'(ri_q) <<< 1) + ext_t'(cim_q));
  assign escaped = (iter_q != '0) && (({1'b0, q_re_q} + {1'b0, q_im_q}) > FOUR);

  assign q_out   = cap_q(mul_p);
  assign q_rem   = prod_rem(mul_p);
  assign ri_full = (zre_q[WORD_W-1] != zim_q[WORD_W-1])
                 ? (ext_t'(0) - ext_t'($signed({3'b000, q_out})) - ext_t'(q_rem))
                 : ext_t'($signed({3'b000, q_out}));

  assign dx = $signed(DX_W'(px_q)) - $signed(DX_W'(WIDTH / 2));
  assign dy = $signed(DX_W'(py_q)) - $signed(DX_W'(HEIGHT / 2));

  assign mul_in_ctl.valid = (state_q == ST_ISSUE);
  assign mul_in_ctl.tag   = tag_q;
  assign mul_a = (tag_q == TAG_SQ_IM) ? mag48(zim_q) : mag48(zre_q);
  assign mul_b = (tag_q == TAG_SQ_RE) ? mag48(zre_q) : mag48(zim_q);

  mbe_mul_chain u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_in_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .ctl_o  (mul_out_ctl),
    .p_o    (mul_p)
  );

  always_comb begin
    state_d  = state_q;
    tag_d    = tag_q;
    iter_d   = iter_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_ISSUE;
        tag_d   = TAG_SQ_RE;
        iter_d  = '0;
      end
      ST_ISSUE: begin
        tag_d = tag_next;
        if (tag_q == TAG_CROSS) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mul_out_ctl.valid && mul_out_ctl.tag == TAG_CROSS) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (escaped || iter_q == ({1'b0, max_iter_q} + (ITER_W+1)'(1))) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_ISSUE;
          iter_d  = iter_q + (ITER_W+1)'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tag_q       <= TAG_SQ_RE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tag_q   <= tag_d;
      iter_q  <= iter_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      px_q <= s_axis_tdata[COORD_W-1:0];
      py_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
    end
    if (state_q == ST_MAP) begin
      pre_re_q <= dx * $signed({1'b0, step_re_q});
      pre_im_q <= dy * $signed({1'b0, step_im_q});
    end
    if (state_q == ST_LOAD) begin
      cre_q <= sat48(ext_t'(pre_re_q) + ext_t'(center_re_q));
      cim_q <= sat48(ext_t'(0) - ext_t'(pre_im_q) - ext_t'(center_im_q));
      zre_q <= sat48(ext_t'(pre_re_q) + ext_t'(center_re_q));
      zim_q <= sat48(ext_t'(0) - ext_t'(pre_im_q) - ext_t'(center_im_q));
    end
    if (state_q == ST_WAIT && mul_out_ctl.valid) begin
      case (mul_out_ctl.tag)
        TAG_SQ_RE: q_re_q <= q_out;
        TAG_SQ_IM: q_im_q <= q_out;
        default:   ri_q   <= sat48(ri_full);
      endcase
    end
    if (state_q == ST_UPDATE) begin
      zre_q    <= nre;
      zim_q    <= nim;
      inside_q <= !escaped;
    end
    if (out_load) begin
      out_x_q      <= px_q;
      out_y_q      <= py_q;
      out_count_q  <= inside_q ? '0 : iter_q[ITER_W-1:0] - ITER_W'(1);
      out_inside_q <= inside_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_count_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_inside_q;

  a_no_product_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mul_out_ctl.valid)
    else $error("Multiplier result arrived while no pixel was in progress.");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE || state_q == ST_WAIT || state_q == ST_UPDATE) |->
    (iter_q <= ({1'b0, max_iter_q} + (ITER_W+1)'(1))))
    else $error("Iteration counter ran past the limit.");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !m_axis_tready) |=> (state_q == ST_DONE))
    else $error("Result left while the output register was still full.");

  a_inside_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_inside_q) |-> (out_count_q == '0))
    else $error("Inside pixel carries a nonzero count.");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the Mandelbrot escape-time evaluator.
// Depends on mbe_pkg and mandelbrot_escape_time; predicts each pixel result in place.
`timescale 1ns / 1ps

module tb_top;
  import mbe_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000000;
  localparam longint      W48_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      W48_MIN     = -64'sh0000_8000_0000_0000;
  localparam longint      STEP_ONE    = 64'sd1 << FRAC_BITS;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ITER_W-1:0]  count;
    logic               in_set;
  } pixel_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [39:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [WORD_W-1:0]    cfg_wdata_i;

  longint          view_center_re;
  longint          view_center_im;
  longint          view_step_re;
  longint          view_step_im;
  int unsigned     view_max_iter;
  pixel_result_t   pending_results[$];
  int unsigned     mismatches;
  int unsigned     stall_cycles;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;

  mandelbrot_escape_time dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint clamp48(input longint v);
    if (v > W48_MAX) begin
      return W48_MAX;
    end else if (v < W48_MIN) begin
      return W48_MIN;
    end
    return v;
  endfunction

  // Magnitude product shifted down by the fraction bits, capped at 2^62.
  function automatic logic [63:0] mag_product(input longint a, input longint b,
                                              output logic rem);
    logic [95:0] ma;
    logic [95:0] mb;
    logic [95:0] p;
    logic [95:0] q;
    ma = (a < 0) ? 96'(-a) : 96'(a);
    mb = (b < 0) ? 96'(-b) : 96'(b);
    p = ma * mb;
    rem = |p[FRAC_BITS-1:0];
    q = p >> FRAC_BITS;
    if (q > 96'h4000_0000_0000_0000) begin
      q = 96'h4000_0000_0000_0000;
    end
    return q[63:0];
  endfunction

  function automatic longint fixed_mul(input longint a, input longint b);
    logic [63:0] q;
    logic        rem;
    q = mag_product(a, b, rem);
    if ((a < 0) != (b < 0)) begin
      return clamp48(-($signed(q) + longint'(rem)));
    end
    return clamp48($signed(q));
  endfunction

  function automatic pixel_result_t escape_time(input logic [COORD_W-1:0] px,
                                                input logic [COORD_W-1:0] py);
    pixel_result_t res;
    longint        c_re;
    longint        c_im;
    longint        z_re;
    longint        z_im;
    longint        rr;
    longint        ii;
    longint        ri;
    logic [63:0]   mod_sq;
    logic          rem;
    c_re = clamp48((longint'(px) - WIDTH / 2) * view_step_re + view_center_re);
    c_im = clamp48(-((longint'(py) - HEIGHT / 2) * view_step_im) - view_center_im);
    z_re = c_re;
    z_im = c_im;
    res.x = px;
    res.y = py;
    res.count = '0;
    res.in_set = 1'b1;
    for (int unsigned n = 0; n <= view_max_iter; n++) begin
      rr = fixed_mul(z_re, z_re);
      ii = fixed_mul(z_im, z_im);
      ri = fixed_mul(z_re, z_im);
      z_re = clamp48(rr - ii + c_re);
      z_im = clamp48(2 * ri + c_im);
      mod_sq = mag_product(z_re, z_re, rem) + mag_product(z_im, z_im, rem);
      if (mod_sq > FOUR) begin
        res.count = n[ITER_W-1:0];
        res.in_set = 1'b0;
        break;
      end
    end
    return res;
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pending_results.push_back(escape_time(s_axis_tdata[9:0], s_axis_tdata[19:10]));
    end
  end

  always @(posedge clk_i) begin
    pixel_result_t exp_res;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result transaction: %h inside %b", m_axis_tdata, m_axis_tuser);
        end
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata[9:0] !== exp_res.x || m_axis_tdata[19:10] !== exp_res.y ||
            m_axis_tdata[35:20] !== exp_res.count || m_axis_tuser !== exp_res.in_set) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected x %0d y %0d count %0d inside %b, got x %0d y %0d count %0d inside %b",
                     exp_res.x, exp_res.y, exp_res.count, exp_res.in_set,
                     m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[35:20],
                     m_axis_tuser);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_pixel(input int unsigned px, input int unsigned py);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, py[9:0], px[9:0]};
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input longint value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[WORD_W-1:0];
    case (idx)
      REG_CENTER_RE: view_center_re = clamp48(value);
      REG_CENTER_IM: view_center_im = clamp48(value);
      REG_STEP_RE:   view_step_re = value & 64'h1FF_FFFF_FFFF;
      REG_STEP_IM:   view_step_im = value & 64'h1FF_FFFF_FFFF;
      REG_MAX_ITER:  view_max_iter = 32'(value & 64'hFFFF);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_view(input longint cre, input longint cim, input longint sre,
                          input longint sim, input longint iters);
    wait_drained();
    write_reg(REG_CENTER_RE, cre);
    write_reg(REG_CENTER_IM, cim);
    write_reg(REG_STEP_RE, sre);
    write_reg(REG_STEP_IM, sim);
    write_reg(REG_MAX_ITER, iters);
  endtask

  task automatic test_reset_view();
    send_pixel(0, 0);
    send_pixel(799, 599);
  endtask

  task automatic test_directed();
    set_view(0, 0, STEP_ONE / 256, STEP_ONE / 256, 40);
    send_pixel(400, 300);
    send_pixel(0, 0);
    send_pixel(799, 599);
    send_pixel(512, 511);
    send_pixel(511, 512);
    send_pixel(300, 200);
    // A zero step maps the whole grid onto the centre.
    set_view(-(STEP_ONE / 2), 0, 0, 0, 12);
    send_pixel(0, 599);
    send_pixel(799, 0);
    // With a zero iteration limit only the first iteration is tried.
    set_view(0, 0, STEP_ONE / 128, STEP_ONE / 128, 0);
    send_pixel(400, 300);
    send_pixel(0, 300);
    send_pixel(799, 599);
    // Extreme centres and steps drive the mapping into saturation.
    set_view(W48_MAX, W48_MIN, STEP_ONE, STEP_ONE, 65535);
    send_pixel(799, 0);
    send_pixel(0, 599);
    send_pixel(400, 300);
    set_view(W48_MIN, W48_MAX, 1, 1, 65535);
    send_pixel(0, 0);
    send_pixel(799, 599);
    set_view(W48_MAX, W48_MAX, STEP_ONE, 1, 3);
    send_pixel(0, 0);
    send_pixel(799, 599);
  endtask

  task automatic test_random_phase(input int unsigned items);
    longint sre;
    sre = longint'($urandom_range(1, 1 << 26)) << $urandom_range(0, 14);
    set_view($signed({$urandom_range(0, 1) ? 16'hFFFF : 16'h0, $urandom, 16'h0}) >>> 16,
             $signed({$urandom_range(0, 1) ? 16'hFFFF : 16'h0, $urandom, 16'h0}) >>> 16,
             sre, $urandom_range(0, 1) ? sre : longint'($urandom_range(1, 1 << 30)),
             $urandom_range(0, 150));
    for (int unsigned i = 0; i < items; i++) begin
      send_pixel($urandom_range(799), $urandom_range(599));
      if ($urandom_range(9) == 0) begin
        wait_drained();
      end
    end
  endtask

  task automatic test_random();
    tx_idle_pct = 25;
    rx_idle_pct = 72;
    for (int p = 0; p < 3; p++) test_random_phase(11);
    tx_idle_pct = 72;
    rx_idle_pct = 25;
    for (int p = 0; p < 3; p++) test_random_phase(11);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int p = 0; p < 3; p++) test_random_phase(12);
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    mismatches     = 0;
    stall_cycles   = 0;
    tx_idle_pct    = 25;
    rx_idle_pct    = 72;
    view_center_re = 64'sd10995116278;
    view_center_im = 64'sd10995116278;
    view_step_re   = 64'sd5497558139;
    view_step_im   = 64'sd7330077518;
    view_max_iter  = 7000;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_view();
    test_directed();
    test_random();

    wait_drained();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mbe_pkg.sv
rtl/mbe_mul_cell.sv
rtl/mbe_mul_chain.sv
rtl/mandelbrot_escape_time.sv
tb/tb_top.sv
